>>> sv/dcpi_pkg.sv
// Shared types and constants for the cascaded PI DC motor controller.
// No dependencies; every other file references this package by scope.
package dcpi_pkg;

    localparam int unsigned GAIN_W    = 31;
    localparam int unsigned VAL_W     = 48;
    localparam int unsigned DUTY_W    = 17;
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [DUTY_W-1:0] DUTY_HALF = 17'd32768;
    localparam logic [DUTY_W-1:0] DUTY_ONE  = 17'd65536;

    typedef enum logic [2:0] {
        REG_APK, REG_AIK, REG_AWK, REG_FPK, REG_FIK, REG_FWK, REG_SPK, REG_SIK
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] GAIN_RESET [NUM_REGS] = '{
        31'd823550, 31'd0, 31'd0, 31'd247064887, 31'd0, 31'd0, 31'd16471, 31'd0
    };

    typedef struct packed {
        logic        [30:0] bus_voltage;
        logic        [30:0] bus_reciprocal;
        logic signed [31:0] armature_current;
        logic signed [31:0] field_current;
        logic signed [31:0] rotor_speed;
        logic               field_enable;
        logic               armature_enable;
        logic signed [31:0] field_current_target;
        logic signed [31:0] speed_target;
    } t_in;

    typedef struct packed {
        logic [16:0] duty_arm_a;
        logic [16:0] duty_arm_b;
        logic [16:0] duty_field_a;
        logic [16:0] duty_field_b;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_WERR, S_SI_LO, S_SI_HI, S_SP_LO, S_SP_HI, S_FFMUL,
        S_IREF, C_KI_LO, C_KI_HI, C_KW_LO, C_KW_HI, C_KP_LO, C_KP_HI, C_VREF,
        C_CLAMP, C_DUTY_MUL, C_DUTY_NMUL, C_DUTY_B, S_FINISH
    } t_state;

    typedef enum logic [1:0] {MOP_NONE, MOP_LO, MOP_HI, MOP_WIDE} t_mop;

    typedef enum logic [2:0] {
        ASEL_ERR, ASEL_EXC, ASEL_VSET, ASEL_NVSET, ASEL_SPEED
    } t_asel;

    typedef enum logic [2:0] {
        GSEL_KI, GSEL_KW, GSEL_KP, GSEL_SIK, GSEL_SPK, GSEL_RECIP, GSEL_IFL
    } t_gsel;

    typedef enum logic [3:0] {
        ALU_NONE, ALU_START, ALU_FERR, ALU_WERR, ALU_SINT, ALU_TORQUE, ALU_IREF,
        ALU_ISUM, ALU_IUPD, ALU_VREF, ALU_CLAMP, ALU_DUTY_A, ALU_DUTY_B
    } t_alu;

    typedef struct packed {
        t_mop  mop;
        t_asel asel;
        t_gsel gsel;
        t_alu  alu;
        logic  arm;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic field_en;
        logic arm_en;
    } t_stat;

endpackage

>>> sv/dcpi_ctrl.sv
// Sequencer for the PI controller: walks the speed and current loop steps.
// Depends on dcpi_pkg; drives dcpi_dpath through t_cmd.
module dcpi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  dcpi_pkg::t_stat i_stat,
    output dcpi_pkg::t_cmd  o_cmd
);

    dcpi_pkg::t_state r_state, n_state;
    logic r_arm, n_arm;
    logic r_out_valid, n_out_valid;
    logic w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == dcpi_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcpi_pkg::S_IDLE;
            r_arm       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_arm       <= n_arm;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_arm   = r_arm;
        unique case (r_state)
            dcpi_pkg::S_IDLE:      if (i_in_valid) n_state = dcpi_pkg::S_DISPATCH;
            dcpi_pkg::S_DISPATCH: begin
                n_arm = 1'b0;
                if (i_stat.field_en)    n_state = dcpi_pkg::C_KI_LO;
                else if (i_stat.arm_en) n_state = dcpi_pkg::S_WERR;
                else                    n_state = dcpi_pkg::S_FINISH;
            end
            dcpi_pkg::S_WERR: begin
                n_arm   = 1'b1;
                n_state = dcpi_pkg::S_SI_LO;
            end
            dcpi_pkg::S_SI_LO:     n_state = dcpi_pkg::S_SI_HI;
            dcpi_pkg::S_SI_HI:     n_state = dcpi_pkg::S_SP_LO;
            dcpi_pkg::S_SP_LO:     n_state = dcpi_pkg::S_SP_HI;
            dcpi_pkg::S_SP_HI:     n_state = dcpi_pkg::S_FFMUL;
            dcpi_pkg::S_FFMUL:     n_state = dcpi_pkg::S_IREF;
            dcpi_pkg::S_IREF:      n_state = dcpi_pkg::C_KI_LO;
            dcpi_pkg::C_KI_LO:     n_state = dcpi_pkg::C_KI_HI;
            dcpi_pkg::C_KI_HI:     n_state = dcpi_pkg::C_KW_LO;
            dcpi_pkg::C_KW_LO:     n_state = dcpi_pkg::C_KW_HI;
            dcpi_pkg::C_KW_HI:     n_state = dcpi_pkg::C_KP_LO;
            dcpi_pkg::C_KP_LO:     n_state = dcpi_pkg::C_KP_HI;
            dcpi_pkg::C_KP_HI:     n_state = dcpi_pkg::C_VREF;
            dcpi_pkg::C_VREF:      n_state = dcpi_pkg::C_CLAMP;
            dcpi_pkg::C_CLAMP:     n_state = dcpi_pkg::C_DUTY_MUL;
            dcpi_pkg::C_DUTY_MUL:  n_state = dcpi_pkg::C_DUTY_NMUL;
            dcpi_pkg::C_DUTY_NMUL: n_state = dcpi_pkg::C_DUTY_B;
            dcpi_pkg::C_DUTY_B: begin
                if (!r_arm && i_stat.arm_en) n_state = dcpi_pkg::S_WERR;
                else                         n_state = dcpi_pkg::S_FINISH;
            end
            dcpi_pkg::S_FINISH:    if (w_out_free) n_state = dcpi_pkg::S_IDLE;
            default:               n_state = dcpi_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.mop      = dcpi_pkg::MOP_NONE;
        o_cmd.asel     = dcpi_pkg::ASEL_ERR;
        o_cmd.gsel     = dcpi_pkg::GSEL_KI;
        o_cmd.alu      = dcpi_pkg::ALU_NONE;
        o_cmd.arm      = r_arm;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            dcpi_pkg::S_IDLE:
                if (i_in_valid) o_cmd.alu = dcpi_pkg::ALU_START;
            dcpi_pkg::S_DISPATCH: o_cmd.alu = dcpi_pkg::ALU_FERR;
            dcpi_pkg::S_WERR:     o_cmd.alu = dcpi_pkg::ALU_WERR;
            dcpi_pkg::S_SI_LO: begin
                o_cmd.mop  = dcpi_pkg::MOP_LO;
                o_cmd.gsel = dcpi_pkg::GSEL_SIK;
            end
            dcpi_pkg::S_SI_HI: begin
                o_cmd.mop  = dcpi_pkg::MOP_HI;
                o_cmd.gsel = dcpi_pkg::GSEL_SIK;
            end
            dcpi_pkg::S_SP_LO: begin
                o_cmd.mop  = dcpi_pkg::MOP_LO;
                o_cmd.gsel = dcpi_pkg::GSEL_SPK;
                o_cmd.alu  = dcpi_pkg::ALU_SINT;
            end
            dcpi_pkg::S_SP_HI: begin
                o_cmd.mop  = dcpi_pkg::MOP_HI;
                o_cmd.gsel = dcpi_pkg::GSEL_SPK;
            end
            dcpi_pkg::S_FFMUL: begin
                o_cmd.mop  = dcpi_pkg::MOP_WIDE;
                o_cmd.asel = dcpi_pkg::ASEL_SPEED;
                o_cmd.gsel = dcpi_pkg::GSEL_IFL;
                o_cmd.alu  = dcpi_pkg::ALU_TORQUE;
            end
            dcpi_pkg::S_IREF:     o_cmd.alu = dcpi_pkg::ALU_IREF;
            dcpi_pkg::C_KI_LO:    o_cmd.mop = dcpi_pkg::MOP_LO;
            dcpi_pkg::C_KI_HI:    o_cmd.mop = dcpi_pkg::MOP_HI;
            dcpi_pkg::C_KW_LO: begin
                o_cmd.mop  = dcpi_pkg::MOP_LO;
                o_cmd.asel = dcpi_pkg::ASEL_EXC;
                o_cmd.gsel = dcpi_pkg::GSEL_KW;
                o_cmd.alu  = dcpi_pkg::ALU_ISUM;
            end
            dcpi_pkg::C_KW_HI: begin
                o_cmd.mop  = dcpi_pkg::MOP_HI;
                o_cmd.asel = dcpi_pkg::ASEL_EXC;
                o_cmd.gsel = dcpi_pkg::GSEL_KW;
            end
            dcpi_pkg::C_KP_LO: begin
                o_cmd.mop  = dcpi_pkg::MOP_LO;
                o_cmd.gsel = dcpi_pkg::GSEL_KP;
                o_cmd.alu  = dcpi_pkg::ALU_IUPD;
            end
            dcpi_pkg::C_KP_HI: begin
                o_cmd.mop  = dcpi_pkg::MOP_HI;
                o_cmd.gsel = dcpi_pkg::GSEL_KP;
            end
            dcpi_pkg::C_VREF:     o_cmd.alu = dcpi_pkg::ALU_VREF;
            dcpi_pkg::C_CLAMP:    o_cmd.alu = dcpi_pkg::ALU_CLAMP;
            dcpi_pkg::C_DUTY_MUL: begin
                o_cmd.mop  = dcpi_pkg::MOP_WIDE;
                o_cmd.asel = dcpi_pkg::ASEL_VSET;
                o_cmd.gsel = dcpi_pkg::GSEL_RECIP;
            end
            dcpi_pkg::C_DUTY_NMUL: begin
                o_cmd.mop  = dcpi_pkg::MOP_WIDE;
                o_cmd.asel = dcpi_pkg::ASEL_NVSET;
                o_cmd.gsel = dcpi_pkg::GSEL_RECIP;
                o_cmd.alu  = dcpi_pkg::ALU_DUTY_A;
            end
            dcpi_pkg::C_DUTY_B:   o_cmd.alu = dcpi_pkg::ALU_DUTY_B;
            dcpi_pkg::S_FINISH:   o_cmd.load_out = w_out_free;
            default:              o_cmd.alu = dcpi_pkg::ALU_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out)   n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

endmodule

>>> sv/dcpi_dpath.sv
// Datapath for the PI controller: gain registers, loop state, shared 33x33
// multiplier with an 80-bit accumulator, and the output register. Uses dcpi_pkg.
module dcpi_dpath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dcpi_pkg::t_in                      i_in_data,
    output dcpi_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    input  logic [dcpi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  dcpi_pkg::t_cmd                     i_cmd,
    output dcpi_pkg::t_stat                    o_stat
);

    localparam int DUTY_SH = 2 * FRAC_BITS - 15;
    localparam logic signed [79:0] MAX48 = 80'sh7FFF_FFFF_FFFF;
    localparam logic signed [79:0] MIN48 = -MAX48 - 80'sd1;

    function automatic logic signed [47:0] sat48(input logic signed [79:0] x);
        if (x > MAX48)      return MAX48[47:0];
        else if (x < MIN48) return MIN48[47:0];
        else                return x[47:0];
    endfunction

    function automatic logic [16:0] duty_of(input logic signed [79:0] p);
        logic signed [79:0] d;
        d = (p >>> DUTY_SH) + 80'sd32768;
        if (d < 0)                           return '0;
        else if (d > 80'sd65536)             return dcpi_pkg::DUTY_ONE;
        else                                 return d[16:0];
    endfunction

    logic [dcpi_pkg::GAIN_W-1:0] r_gain [dcpi_pkg::NUM_REGS];
    dcpi_pkg::t_in  r_in;
    dcpi_pkg::t_out r_duty, r_out;
    logic signed [47:0] r_fint, r_fexc, r_sint, r_aint, r_aexc;
    logic signed [47:0] r_err, r_vref, r_ff;
    logic signed [49:0] r_tmp;
    logic signed [31:0] r_vset;
    logic signed [79:0] r_acc;

    logic signed [47:0] w_opa, w_integ, w_mres, w_vdc, w_vset_w;
    logic [30:0]        w_g;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;

    assign o_stat.field_en = r_in.field_enable;
    assign o_stat.arm_en   = r_in.armature_enable;
    assign o_out_data      = r_out;

    assign w_integ = i_cmd.arm ? r_aint : r_fint;
    assign w_mres  = sat48(r_acc >>> FRAC_BITS);
    assign w_vdc   = 48'(r_in.bus_voltage);

    always_comb begin
        case (i_cmd.asel)
            dcpi_pkg::ASEL_EXC: w_opa = i_cmd.arm ? r_aexc : r_fexc;
            default:            w_opa = r_err;
        endcase
    end

    always_comb begin
        unique case (i_cmd.gsel)
            dcpi_pkg::GSEL_KI:    w_g = r_gain[i_cmd.arm ? dcpi_pkg::REG_AIK : dcpi_pkg::REG_FIK];
            dcpi_pkg::GSEL_KW:    w_g = r_gain[i_cmd.arm ? dcpi_pkg::REG_AWK : dcpi_pkg::REG_FWK];
            dcpi_pkg::GSEL_KP:    w_g = r_gain[i_cmd.arm ? dcpi_pkg::REG_APK : dcpi_pkg::REG_FPK];
            dcpi_pkg::GSEL_SIK:   w_g = r_gain[dcpi_pkg::REG_SIK];
            dcpi_pkg::GSEL_SPK:   w_g = r_gain[dcpi_pkg::REG_SPK];
            dcpi_pkg::GSEL_RECIP: w_g = r_in.bus_reciprocal;
            default:              w_g = '0;
        endcase
    end

    // multiplier operands: 48-bit values go through in two 24-bit halves
    always_comb begin
        w_mb = (i_cmd.gsel == dcpi_pkg::GSEL_IFL) ? 33'(r_in.field_current)
                                                  : $signed({2'b00, w_g});
        case (i_cmd.mop)
            dcpi_pkg::MOP_LO: w_ma = $signed({9'b0, w_opa[23:0]});
            dcpi_pkg::MOP_HI: w_ma = 33'($signed(w_opa[47:24]));
            dcpi_pkg::MOP_WIDE: begin
                case (i_cmd.asel)
                    dcpi_pkg::ASEL_VSET:  w_ma = 33'(r_vset);
                    dcpi_pkg::ASEL_NVSET: w_ma = -33'(r_vset);
                    default:              w_ma = 33'(r_in.rotor_speed);
                endcase
            end
            default: w_ma = '0;
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_comb begin
        if (r_vref > w_vdc)       w_vset_w = w_vdc;
        else if (r_vref < -w_vdc) w_vset_w = -w_vdc;
        else                      w_vset_w = r_vref;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dcpi_pkg::NUM_REGS; i++) r_gain[i] <= dcpi_pkg::GAIN_RESET[i];
        end else if (i_cfg_valid && i_cfg_index < dcpi_pkg::CFG_IDX_W'(dcpi_pkg::NUM_REGS)) begin
            r_gain[i_cfg_index[2:0]] <= i_cfg_data[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fint <= '0;
            r_fexc <= '0;
            r_sint <= '0;
            r_aint <= '0;
            r_aexc <= '0;
        end else begin
            case (i_cmd.alu)
                dcpi_pkg::ALU_SINT: r_sint <= sat48(80'(r_sint) + 80'(w_mres));
                dcpi_pkg::ALU_IUPD: begin
                    if (i_cmd.arm) r_aint <= sat48(80'(r_tmp) - 80'(w_mres));
                    else           r_fint <= sat48(80'(r_tmp) - 80'(w_mres));
                end
                dcpi_pkg::ALU_CLAMP: begin
                    if (i_cmd.arm) r_aexc <= r_vref - w_vset_w;
                    else           r_fexc <= r_vref - w_vset_w;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.mop)
            dcpi_pkg::MOP_LO, dcpi_pkg::MOP_WIDE: r_acc <= 80'(w_prod);
            dcpi_pkg::MOP_HI: r_acc <= r_acc + (80'(w_prod) <<< 24);
            default: ;
        endcase
        if (i_cmd.load_out) r_out <= r_duty;
        unique case (i_cmd.alu)
            dcpi_pkg::ALU_START: begin
                r_in   <= i_in_data;
                r_duty <= {4{dcpi_pkg::DUTY_HALF}};
            end
            dcpi_pkg::ALU_FERR:
                r_err <= 48'(r_in.field_current_target) - 48'(r_in.field_current);
            dcpi_pkg::ALU_WERR:
                r_err <= 48'(r_in.speed_target) - 48'(r_in.rotor_speed);
            dcpi_pkg::ALU_TORQUE: r_tmp <= 50'(sat48(80'(r_sint) + 80'(w_mres)));
            dcpi_pkg::ALU_IREF: begin
                // armature current reference is five times torque
                r_ff  <= sat48(r_acc >>> (FRAC_BITS - 1));
                r_err <= sat48(80'(sat48((80'(r_tmp) <<< 2) + 80'(r_tmp)))
                               - 80'(r_in.armature_current));
            end
            dcpi_pkg::ALU_ISUM: r_tmp <= 50'(w_integ) + 50'(w_mres);
            dcpi_pkg::ALU_VREF:
                r_vref <= sat48(80'(sat48(80'(w_integ) + (i_cmd.arm ? 80'(r_ff) : 80'sd0)))
                                + 80'(w_mres));
            dcpi_pkg::ALU_CLAMP: r_vset <= w_vset_w[31:0];
            dcpi_pkg::ALU_DUTY_A: begin
                if (i_cmd.arm) r_duty.duty_arm_a   <= duty_of(r_acc);
                else           r_duty.duty_field_a <= duty_of(r_acc);
            end
            dcpi_pkg::ALU_DUTY_B: begin
                if (i_cmd.arm) r_duty.duty_arm_b   <= duty_of(r_acc);
                else           r_duty.duty_field_b <= duty_of(r_acc);
            end
            default: ;
        endcase
    end

endmodule

>>> sv/dc_motor_cascade_pi_controller_top.sv
// Cascaded speed/current PI controller for a separately excited DC motor.
// Each sample runs the enabled loops, field loop first, then armature loop;
// one sample at a time, paced by a single shared 33x33 multiplier that every
// gain product and duty product goes through.
// Result register frees the input side: next sample is taken while a result waits.
// Reset (synchronous, active low): gains to defaults, integrators and excess to 0.
module dc_motor_cascade_pi_controller_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dcpi_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dcpi_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dcpi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    dcpi_pkg::t_cmd  w_cmd;
    dcpi_pkg::t_stat w_stat;

    // gain writes are registered directly, always ready
    assign o_cfg_ready = 1'b1;

    // sequencer: state machine, loop select and result valid
    dcpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: operands, multiplier, loop state, result register
    dcpi_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    // one sample in flight: no second transfer right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a sample is in progress");

    // result valid only comes up from the result register load
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("result valid without a result load");

    // duties stay within 0..1.0
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.duty_arm_a <= dcpi_pkg::DUTY_ONE &&
                         o_out_data.duty_arm_b <= dcpi_pkg::DUTY_ONE &&
                         o_out_data.duty_field_a <= dcpi_pkg::DUTY_ONE &&
                         o_out_data.duty_field_b <= dcpi_pkg::DUTY_ONE))
        else $error("duty out of range");

endmodule

>>> bench/dc_motor_cascade_pi_controller_top_test.sv
// Self-checking bench for dc_motor_cascade_pi_controller_top.
// Depends on dcpi_pkg and the top-level RTL only.
module dc_motor_cascade_pi_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 40;   // outlasts the longest sample
    localparam int RANDOM_ITEMS = 1860;

    typedef logic signed [95:0] t_wide;
    localparam longint Q48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint Q48_MIN = -Q48_MAX - 1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    dcpi_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    dcpi_pkg::t_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [dcpi_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    dc_motor_cascade_pi_controller_top #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: gains plus the loop integrators and excess terms.
    logic [dcpi_pkg::GAIN_W-1:0] gain_q [dcpi_pkg::NUM_REGS];
    longint fld_integ, fld_excess, spd_integ, arm_integ, arm_excess;
    dcpi_pkg::t_out duty_queue [$];

    int mismatches = 0;
    int cycles = 0;
    bit sender_gaps = 1'b1;
    bit hold_off = 1'b0;

    function automatic longint sat48(t_wide x);
        if (x > t_wide'(Q48_MAX)) return Q48_MAX;
        if (x < t_wide'(Q48_MIN)) return Q48_MIN;
        return longint'(x);
    endfunction

    // floor(a*g / 2^F), saturated
    function automatic longint scale_by_gain(longint a, longint g);
        t_wide p;
        p = t_wide'(a) * t_wide'(g);
        return sat48(p >>> FRAC);
    endfunction

    function automatic logic [16:0] leg_duty(longint v, longint recip);
        t_wide d;
        d = ((t_wide'(v) * t_wide'(recip)) >>> (2 * FRAC - 15)) + 32768;
        if (d < 0) return 17'd0;
        if (d > 65536) return dcpi_pkg::DUTY_ONE;
        return d[16:0];
    endfunction

    function automatic void current_pi(input longint err, input longint ff,
                                       input longint vdc, input longint recip,
                                       input longint kp, input longint ki,
                                       input longint kw, inout longint integ,
                                       inout longint excess,
                                       output logic [16:0] da, output logic [16:0] db);
        longint vref, vset;
        integ = sat48(t_wide'(integ) + scale_by_gain(err, ki)
                      - scale_by_gain(excess, kw));
        vref = sat48(t_wide'(sat48(t_wide'(integ) + ff)) + scale_by_gain(err, kp));
        if (vref > vdc) vset = vdc;
        else if (vref < -vdc) vset = -vdc;
        else vset = vref;
        excess = sat48(t_wide'(vref) - vset);
        da = leg_duty(vset, recip);
        db = leg_duty(-vset, recip);
    endfunction

    function automatic dcpi_pkg::t_out predict_duties(dcpi_pkg::t_in s);
        dcpi_pkg::t_out r;
        longint vdc, recip, werr, torque, iref, ff;
        vdc = longint'(s.bus_voltage);
        recip = longint'(s.bus_reciprocal);
        r = '{dcpi_pkg::DUTY_HALF, dcpi_pkg::DUTY_HALF,
              dcpi_pkg::DUTY_HALF, dcpi_pkg::DUTY_HALF};
        if (s.field_enable)
            current_pi(longint'(s.field_current_target) - longint'(s.field_current), 0,
                       vdc, recip, gain_q[dcpi_pkg::REG_FPK], gain_q[dcpi_pkg::REG_FIK],
                       gain_q[dcpi_pkg::REG_FWK],
                       fld_integ, fld_excess, r.duty_field_a, r.duty_field_b);
        if (s.armature_enable) begin
            werr = longint'(s.speed_target) - longint'(s.rotor_speed);
            spd_integ = sat48(t_wide'(spd_integ)
                              + scale_by_gain(werr, gain_q[dcpi_pkg::REG_SIK]));
            torque = sat48(t_wide'(spd_integ)
                           + scale_by_gain(werr, gain_q[dcpi_pkg::REG_SPK]));
            iref = sat48(t_wide'(torque) * 5);
            ff = sat48((t_wide'(s.rotor_speed) * t_wide'(s.field_current)) >>> (FRAC - 1));
            current_pi(sat48(t_wide'(iref) - longint'(s.armature_current)), ff,
                       vdc, recip, gain_q[dcpi_pkg::REG_APK], gain_q[dcpi_pkg::REG_AIK],
                       gain_q[dcpi_pkg::REG_AWK],
                       arm_integ, arm_excess, r.duty_arm_a, r.duty_arm_b);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(99) < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Output side: random stalls, plus a long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off || stall_left > 0) begin
                i_out_ready <= 1'b0;
                if (stall_left > 0) stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (sender_gaps && $urandom_range(7) == 0) stall_left = pick_gap();
            end
        end
    end

    // Result checker: each transfer against the oldest expectation.
    always @(posedge i_clk) begin
        dcpi_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (duty_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                want = duty_queue.pop_front();
                if (want.duty_arm_a !== o_out_data.duty_arm_a ||
                    want.duty_arm_b !== o_out_data.duty_arm_b ||
                    want.duty_field_a !== o_out_data.duty_field_a ||
                    want.duty_field_b !== o_out_data.duty_field_b) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("duty mismatch: expected %p, got %p", want, o_out_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One sample transfer; prediction is taken at the accepting edge.
    task automatic send_sample(dcpi_pkg::t_in s);
        int gap;
        gap = sender_gaps ? ($urandom_range(3) == 0 ? pick_gap() : 0) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        duty_queue.push_back(predict_duties(s));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(int idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= dcpi_pkg::CFG_IDX_W'(idx);
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < dcpi_pkg::NUM_REGS) gain_q[idx] = value[dcpi_pkg::GAIN_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mode 0: realistic gains, 1: all max, 2: all zero, 3: fully random
    task automatic load_gains(int mode);
        logic [31:0] v;
        wait_idle();
        for (int r = 0; r < dcpi_pkg::NUM_REGS; r++) begin
            case (mode)
                0: v = (r == dcpi_pkg::REG_APK || r == dcpi_pkg::REG_FPK ||
                        r == dcpi_pkg::REG_SPK)
                       ? $urandom_range(1 << 20, 1 << 12) : $urandom_range(1 << 12);
                1: v = 32'hFFFF_FFFF;
                2: v = 32'h8000_0000;   // top bit dropped, leaves zero
                default: v = $urandom;
            endcase
            write_gain(r, v);
        end
        write_gain(dcpi_pkg::NUM_REGS + $urandom_range(200), $urandom);   // no such register
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(1 << $urandom_range(22, 4))) -
                            $signed($urandom_range(1 << 21));
        endcase
    endfunction

    function automatic dcpi_pkg::t_in random_sample(bit sane);
        dcpi_pkg::t_in s;
        s.bus_voltage = sane ? 31'($urandom_range(600 << 16, 12 << 16)) : 31'($urandom);
        s.bus_reciprocal = sane ? 31'((64'd1 << 32) / s.bus_voltage) : 31'($urandom);
        s.armature_current = pick_value();
        s.field_current = pick_value();
        s.rotor_speed = pick_value();
        s.field_current_target = pick_value();
        s.speed_target = pick_value();
        s.field_enable = $urandom_range(9) != 0;
        s.armature_enable = $urandom_range(9) != 0;
        return s;
    endfunction

    task automatic test_directed();
        dcpi_pkg::t_in s;
        s = '0;
        for (int k = 0; k < 4; k++) begin        // enable combinations, all zero
            {s.field_enable, s.armature_enable} = 2'(k);
            send_sample(s);
        end
        s = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh8000_0000, 32'sh8000_0000};
        send_sample(s);
        s = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 1'b1, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_sample(s);
        s.bus_voltage = '0;                     // zero bus pins both legs at half
        send_sample(s);
        s = '{31'd24 << 16, 31'd2731, -32'sd1 << 16, 32'sd1 << 16, 32'sd100 << 16,
              1'b1, 1'b1, 32'sd2 << 16, 32'sd150 << 16};
        repeat (4) send_sample(s);              // repeated error grows integrators
        s.field_enable = 1'b0;                  // held field state
        send_sample(s);
        s.armature_enable = 1'b0;
        s.field_enable = 1'b1;
        send_sample(s);
        s.bus_reciprocal = 31'h7FFF_FFFF;       // duty saturates to 0 and 1
        send_sample(s);
        s = '1;
        send_sample(s);
        s = '0;
        s.field_enable = 1'b1;
        s.armature_enable = 1'b1;
        s.bus_voltage = 31'd1;
        send_sample(s);
    endtask

    task automatic test_gain_settings();
        int setting;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 155 == 0) begin
                setting = (n / 155) % 4;
                load_gains(setting);
                sender_gaps = (n / 155) % 3 != 1;   // some stretches run back to back
            end
            send_sample(random_sample($urandom_range(4) != 0));
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 12; n++) send_sample(random_sample(1'b1));
        join
    endtask

    initial begin
        for (int r = 0; r < dcpi_pkg::NUM_REGS; r++) gain_q[r] = dcpi_pkg::GAIN_RESET[r];
        fld_integ = 0;
        fld_excess = 0;
        spd_integ = 0;
        arm_integ = 0;
        arm_excess = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_gain_settings();
        load_gains(1);
        test_directed();

        wait_idle();
        if (mismatches == 0 && duty_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
